### hdl/cise_pkg.sv
// Shared types, opcodes and helpers for the instruction-subset executor.
// Used by cise_alu, cpu_instruction_subset_executor_top and its testbench.
package cise_pkg;

	localparam int MEM_ADDR_BITS = 16;
	localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_EXEC  = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam logic [4:0] F_Z  = 5'h01;
	localparam logic [4:0] F_S  = 5'h02;
	localparam logic [4:0] F_P  = 5'h04;
	localparam logic [4:0] F_CY = 5'h08;

	// Supported opcodes.
	localparam logic [7:0] OP_NOP = 8'h00, OP_NOP_ALT = 8'h20, OP_LXI_B = 8'h01,
		OP_DCR_B = 8'h05, OP_MVI_B = 8'h06, OP_DAD_B = 8'h09, OP_DCR_C = 8'h0d,
		OP_MVI_C = 8'h0e, OP_RRC = 8'h0f, OP_LXI_D = 8'h11, OP_INX_D = 8'h13,
		OP_DAD_D = 8'h19, OP_LDAX_D = 8'h1a, OP_DCX_D = 8'h1b, OP_LXI_H = 8'h21,
		OP_INX_H = 8'h23, OP_INR_H = 8'h24, OP_MVI_H = 8'h26, OP_DAD_H = 8'h29,
		OP_LXI_SP = 8'h31, OP_STA = 8'h32, OP_MVI_M = 8'h36, OP_LDA = 8'h3a,
		OP_MVI_A = 8'h3e, OP_MOV_DM = 8'h56, OP_MOV_EM = 8'h5e, OP_MOV_HM = 8'h66,
		OP_MOV_LA = 8'h6f, OP_MOV_MA = 8'h77, OP_MOV_AD = 8'h7a, OP_MOV_AE = 8'h7b,
		OP_MOV_AH = 8'h7c, OP_MOV_AM = 8'h7e, OP_ANA_A = 8'ha7, OP_XRA_A = 8'haf,
		OP_ORA_M = 8'hb6, OP_POP_B = 8'hc1, OP_JNZ = 8'hc2, OP_JMP = 8'hc3,
		OP_PUSH_B = 8'hc5, OP_ADI = 8'hc6, OP_RET = 8'hc9, OP_CALL = 8'hcd,
		OP_POP_D = 8'hd1, OP_OUT = 8'hd3, OP_PUSH_D = 8'hd5, OP_POP_H = 8'he1,
		OP_PUSH_H = 8'he5, OP_ANI = 8'he6, OP_XCHG = 8'heb, OP_POP_PSW = 8'hf1,
		OP_PUSH_PSW = 8'hf5, OP_EI = 8'hfb, OP_CPI = 8'hfe;

	// ALU operations shared by the sequencer and the arithmetic unit.
	typedef enum logic [2:0] {
		ALU_ADD16,
		ALU_SUB16,
		ALU_ADD8,
		ALU_SUB8,
		ALU_AND8,
		ALU_OR8
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [15:0] a;
		logic [15:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] res;
		logic        carry;
		logic [4:0]  zsp;
	} alu_rsp_t;

	function automatic logic [MEM_ADDR_BITS-1:0] maddr(input logic [15:0] a);
		return a[MEM_ADDR_BITS-1:0];
	endfunction

endpackage

### hdl/cise_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module cise_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### hdl/cise_alu.sv
// Shared 16-bit adder, subtractor and logic unit with zero/sign/parity.
// Depends on cise_pkg.
module cise_alu (
	input  cise_pkg::alu_req_t req,
	output cise_pkg::alu_rsp_t rsp
);
	logic [16:0] sum;
	logic [7:0]  r8;

	always_comb begin
		sum = 17'd0;
		unique case (req.op)
			cise_pkg::ALU_ADD16: sum = {1'b0, req.a} + {1'b0, req.b};
			cise_pkg::ALU_SUB16: sum = {1'b0, req.a} - {1'b0, req.b};
			cise_pkg::ALU_ADD8:  sum = {9'd0, req.a[7:0]} + {9'd0, req.b[7:0]};
			cise_pkg::ALU_SUB8:  sum = {9'd0, req.a[7:0]} - {9'd0, req.b[7:0]};
			cise_pkg::ALU_AND8:  sum = {9'd0, req.a[7:0] & req.b[7:0]};
			cise_pkg::ALU_OR8:   sum = {9'd0, req.a[7:0] | req.b[7:0]};
			default:             sum = 17'd0;
		endcase
		r8 = sum[7:0];
		rsp.res = sum[15:0];
		// For byte operations the borrow or carry sits in bit 8.
		rsp.carry = (req.op == cise_pkg::ALU_ADD16) ? sum[16] : sum[8];
		rsp.zsp = ((r8 == 8'd0) ? cise_pkg::F_Z : 5'd0)
			| (r8[7] ? cise_pkg::F_S : 5'd0)
			| (~^r8 ? cise_pkg::F_P : 5'd0);
	end
endmodule

### hdl/cpu_instruction_subset_executor_top.sv
// Top level: sequencer, register file and memory of the instruction executor.
// Depends on cise_pkg, cise_ram and cise_alu.
//
//  port group   dir  contents
//  s_axis_*     in   command requests: tdata = command, address, write_byte
//  m_axis_*     out  register state after each request
//
// A write or spare request goes from acceptance straight to the result; a read
// passes through a read state first. An instruction makes three serial fetches of
// opcode and operands, waits for the registered read and then decodes. A data store
// or load passes through ST_MEM1 and a push, call, pop or return through ST_MEM1 and
// ST_MEM2 before decode, all through the one memory port. One request is in work at
// a time; s_axis_tready is low from acceptance until the result is taken. arst_n
// clears registers; memory content is undefined until written.
module cpu_instruction_subset_executor_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,  // command[1:0], address[17:2], write_byte[25:18]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata  // read_byte, program_counter, stack_pointer,
	                                   // accumulator, pair_bc, pair_de, pair_hl,
	                                   // flag_bits, interrupts_enabled, unimplemented
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_FOP, ST_FB1, ST_FB2, ST_WAIT, ST_DEC,
		ST_MEM1, ST_MEM2, ST_RD, ST_OUT
	} state_t;

	state_t      state_q;
	logic [7:0]  wb_q;
	logic [7:0]  op_q, b1_q, b2_q, rb_q;
	logic [15:0] pc_q, sp_q;
	logic [7:0]  a_q, b_q, c_q, d_q, e_q, h_q, l_q;
	logic [4:0]  f_q;
	logic        ie_q, un_q;
	logic [2:0]  cnt_q;

	logic        we;
	logic [15:0] ma;
	logic [7:0]  wd, rd;
	cise_pkg::alu_req_t areq;
	cise_pkg::alu_rsp_t arsp;

	cise_ram #(.WIDTH(8), .DEPTH(cise_pkg::MEM_DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(cise_pkg::maddr(ma)), .wdata(wd), .rdata(rd)
	);
	cise_alu u_alu (.req(areq), .rsp(arsp));

	logic [15:0] imm16, hl, de, bc;
	assign imm16 = {b2_q, b1_q};
	assign hl = {h_q, l_q};
	assign de = {d_q, e_q};
	assign bc = {b_q, c_q};

	logic is_push, is_pop, is_call, is_ret, mem_rd_op, mem_wr_op;
	logic [7:0] push_hi, push_lo;
	logic [15:0] data_addr;
	always_comb begin
		is_push = op_q inside {cise_pkg::OP_PUSH_B, cise_pkg::OP_PUSH_D,
			cise_pkg::OP_PUSH_H, cise_pkg::OP_PUSH_PSW};
		is_pop = op_q inside {cise_pkg::OP_POP_B, cise_pkg::OP_POP_D,
			cise_pkg::OP_POP_H, cise_pkg::OP_POP_PSW};
		is_call = (op_q == cise_pkg::OP_CALL);
		is_ret = (op_q == cise_pkg::OP_RET);
		mem_rd_op = op_q inside {cise_pkg::OP_LDAX_D, cise_pkg::OP_LDA, cise_pkg::OP_MOV_DM,
			cise_pkg::OP_MOV_EM, cise_pkg::OP_MOV_HM, cise_pkg::OP_MOV_AM,
			cise_pkg::OP_ORA_M};
		mem_wr_op = op_q inside {cise_pkg::OP_STA, cise_pkg::OP_MVI_M, cise_pkg::OP_MOV_MA};
		unique case (op_q)
			cise_pkg::OP_PUSH_B:   begin push_hi = b_q; push_lo = c_q; end
			cise_pkg::OP_PUSH_D:   begin push_hi = d_q; push_lo = e_q; end
			cise_pkg::OP_PUSH_H:   begin push_hi = h_q; push_lo = l_q; end
			cise_pkg::OP_PUSH_PSW: begin push_hi = a_q; push_lo = {3'd0, f_q}; end
			default: begin push_hi = arsp.res[15:8]; push_lo = arsp.res[7:0]; end
		endcase
		unique case (op_q)
			cise_pkg::OP_LDAX_D:                  data_addr = de;
			cise_pkg::OP_STA, cise_pkg::OP_LDA: data_addr = imm16;
			default:                              data_addr = hl;
		endcase
	end

	// Memory port and shared-unit requests for each sequencer step.
	always_comb begin
		we = 1'b0;
		ma = pc_q;
		wd = wb_q;
		areq.op = cise_pkg::ALU_ADD16;
		areq.a = pc_q;
		areq.b = 16'd0;
		unique case (state_q)
			ST_IDLE: begin
				ma = s_axis_tdata[17:2];
				wd = s_axis_tdata[25:18];
				we = s_axis_tvalid && (s_axis_tdata[1:0] == cise_pkg::CMD_WRITE);
			end
			ST_FOP: ma = pc_q;
			ST_FB1: begin areq.b = 16'd1; ma = arsp.res; end
			ST_FB2: begin areq.b = 16'd2; ma = arsp.res; end
			// The return address of a call is staged in pc_q here.
			ST_WAIT: areq.b = 16'd3;
			ST_MEM1: begin
				if (is_push || is_call) begin
					areq.a = sp_q; areq.op = cise_pkg::ALU_SUB16; areq.b = 16'd1;
					ma = arsp.res; we = 1'b1;
					wd = is_call ? pc_q[15:8] : push_hi;
				end else if (is_pop || is_ret) begin
					ma = sp_q;
				end else begin
					ma = data_addr; we = mem_wr_op;
					wd = (op_q == cise_pkg::OP_MVI_M) ? b1_q : a_q;
				end
			end
			ST_MEM2: begin
				areq.a = sp_q;
				if (is_push || is_call) begin
					areq.op = cise_pkg::ALU_SUB16; areq.b = 16'd2;
					ma = arsp.res; we = 1'b1;
					wd = is_call ? pc_q[7:0] : push_lo;
				end else begin
					areq.b = 16'd1; ma = arsp.res;
				end
			end
			ST_DEC: begin
				unique case (op_q)
					cise_pkg::OP_DCR_B: begin
						areq.op = cise_pkg::ALU_SUB8; areq.a = {8'd0, b_q}; areq.b = 16'd1;
					end
					cise_pkg::OP_DCR_C: begin
						areq.op = cise_pkg::ALU_SUB8; areq.a = {8'd0, c_q}; areq.b = 16'd1;
					end
					cise_pkg::OP_INR_H: begin
						areq.op = cise_pkg::ALU_ADD8; areq.a = {8'd0, h_q}; areq.b = 16'd1;
					end
					cise_pkg::OP_DAD_B: begin areq.a = hl; areq.b = bc; end
					cise_pkg::OP_DAD_D: begin areq.a = hl; areq.b = de; end
					cise_pkg::OP_DAD_H: begin areq.a = hl; areq.b = hl; end
					cise_pkg::OP_INX_D: begin areq.a = de; areq.b = 16'd1; end
					cise_pkg::OP_DCX_D: begin
						areq.op = cise_pkg::ALU_SUB16; areq.a = de; areq.b = 16'd1;
					end
					cise_pkg::OP_INX_H: begin areq.a = hl; areq.b = 16'd1; end
					cise_pkg::OP_ADI: begin
						areq.op = cise_pkg::ALU_ADD8; areq.a = {8'd0, a_q};
						areq.b = {8'd0, b1_q};
					end
					cise_pkg::OP_CPI: begin
						areq.op = cise_pkg::ALU_SUB8; areq.a = {8'd0, a_q};
						areq.b = {8'd0, b1_q};
					end
					cise_pkg::OP_ANI: begin
						areq.op = cise_pkg::ALU_AND8; areq.a = {8'd0, a_q};
						areq.b = {8'd0, b1_q};
					end
					cise_pkg::OP_ANA_A: begin
						areq.op = cise_pkg::ALU_AND8; areq.a = {8'd0, a_q};
						areq.b = {8'd0, a_q};
					end
					cise_pkg::OP_XRA_A: begin
						areq.op = cise_pkg::ALU_AND8; areq.a = 16'd0; areq.b = 16'd0;
					end
					cise_pkg::OP_ORA_M: begin
						areq.op = cise_pkg::ALU_OR8; areq.a = {8'd0, a_q};
						areq.b = {8'd0, rb_q};
					end
					default: begin areq.a = pc_q; areq.b = 16'd0; end
				endcase
			end
			default: ;
		endcase
	end

	logic [4:0] zsp_f, cy_f;
	assign zsp_f = (f_q & ~(cise_pkg::F_Z | cise_pkg::F_S | cise_pkg::F_P)) | arsp.zsp;
	assign cy_f = arsp.carry ? cise_pkg::F_CY : 5'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= 16'd0; sp_q <= 16'd0;
			a_q <= 8'd0; b_q <= 8'd0; c_q <= 8'd0; d_q <= 8'd0;
			e_q <= 8'd0; h_q <= 8'd0; l_q <= 8'd0;
			f_q <= 5'd0; ie_q <= 1'b0; un_q <= 1'b0;
			cnt_q <= 3'd0; rb_q <= 8'd0;
			wb_q <= 8'd0;
			op_q <= 8'd0; b1_q <= 8'd0; b2_q <= 8'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					wb_q <= s_axis_tdata[25:18];
					rb_q <= 8'd0;
					un_q <= 1'b0;
					if (s_axis_tdata[1:0] == cise_pkg::CMD_EXEC) begin
						state_q <= ST_FOP;
					end else if (s_axis_tdata[1:0] == cise_pkg::CMD_READ) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_RD: begin rb_q <= rd; state_q <= ST_OUT; end
				ST_FOP: state_q <= ST_FB1;
				ST_FB1: begin op_q <= rd; state_q <= ST_FB2; end
				ST_FB2: begin b1_q <= rd; state_q <= ST_WAIT; end
				ST_WAIT: begin
					b2_q <= rd; cnt_q <= 3'd0;
					if (is_call) pc_q <= arsp.res;
					state_q <= (is_push || is_pop || is_call || is_ret || mem_rd_op || mem_wr_op)
						? ST_MEM1 : ST_DEC;
				end
				ST_MEM1: begin
					cnt_q <= cnt_q + 3'd1;
					if (is_push || is_call || is_pop || is_ret) begin
						state_q <= ST_MEM2;
					end else if (mem_rd_op && cnt_q == 3'd0) begin
						state_q <= ST_MEM1;
					end else begin
						if (mem_rd_op) rb_q <= rd;
						state_q <= ST_DEC;
					end
				end
				ST_MEM2: begin
					cnt_q <= cnt_q + 3'd1;
					if (is_pop || is_ret) begin
						if (cnt_q == 3'd1) begin
							b1_q <= rd;
							state_q <= ST_MEM2;
						end else begin
							b2_q <= rd;
							state_q <= ST_DEC;
						end
					end else begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					state_q <= ST_OUT;
					// A loaded data byte is consumed here; read_byte reports zero.
					rb_q <= 8'd0;
					pc_q <= pc_q + 16'd1;
					unique case (op_q)
						cise_pkg::OP_NOP, cise_pkg::OP_NOP_ALT, cise_pkg::OP_OUT: ;
						cise_pkg::OP_LXI_B: begin c_q <= b1_q; b_q <= b2_q; end
						cise_pkg::OP_LXI_D: begin e_q <= b1_q; d_q <= b2_q; end
						cise_pkg::OP_LXI_H: begin l_q <= b1_q; h_q <= b2_q; end
						cise_pkg::OP_LXI_SP: sp_q <= imm16;
						cise_pkg::OP_DCR_B: begin b_q <= arsp.res[7:0]; f_q <= zsp_f; end
						cise_pkg::OP_DCR_C: begin c_q <= arsp.res[7:0]; f_q <= zsp_f; end
						cise_pkg::OP_INR_H: begin h_q <= arsp.res[7:0]; f_q <= zsp_f; end
						cise_pkg::OP_MVI_B: b_q <= b1_q;
						cise_pkg::OP_MVI_C: c_q <= b1_q;
						cise_pkg::OP_MVI_H: h_q <= b1_q;
						cise_pkg::OP_MVI_A: a_q <= b1_q;
						cise_pkg::OP_DAD_B, cise_pkg::OP_DAD_D, cise_pkg::OP_DAD_H: begin
							{h_q, l_q} <= arsp.res;
							f_q <= (f_q & ~cise_pkg::F_CY) | cy_f;
						end
						cise_pkg::OP_RRC: begin
							a_q <= {a_q[0], a_q[7:1]};
							f_q <= (f_q & ~cise_pkg::F_CY) | (a_q[0] ? cise_pkg::F_CY : 5'd0);
						end
						cise_pkg::OP_INX_D, cise_pkg::OP_DCX_D: {d_q, e_q} <= arsp.res;
						cise_pkg::OP_INX_H: {h_q, l_q} <= arsp.res;
						cise_pkg::OP_LDAX_D, cise_pkg::OP_LDA, cise_pkg::OP_MOV_AM: a_q <= rb_q;
						cise_pkg::OP_MOV_DM: d_q <= rb_q;
						cise_pkg::OP_MOV_EM: e_q <= rb_q;
						cise_pkg::OP_MOV_HM: h_q <= rb_q;
						cise_pkg::OP_STA, cise_pkg::OP_MVI_M, cise_pkg::OP_MOV_MA: ;
						cise_pkg::OP_MOV_LA: l_q <= a_q;
						cise_pkg::OP_MOV_AD: a_q <= d_q;
						cise_pkg::OP_MOV_AE: a_q <= e_q;
						cise_pkg::OP_MOV_AH: a_q <= h_q;
						cise_pkg::OP_ANA_A, cise_pkg::OP_XRA_A, cise_pkg::OP_ORA_M,
						cise_pkg::OP_ANI: begin
							a_q <= arsp.res[7:0];
							f_q <= zsp_f & ~cise_pkg::F_CY;
						end
						cise_pkg::OP_ADI: begin
							a_q <= arsp.res[7:0];
							f_q <= (zsp_f & ~cise_pkg::F_CY) | cy_f;
						end
						cise_pkg::OP_CPI: f_q <= (zsp_f & ~cise_pkg::F_CY) | cy_f;
						cise_pkg::OP_POP_B: begin
							c_q <= b1_q; b_q <= b2_q; sp_q <= sp_q + 16'd2;
						end
						cise_pkg::OP_POP_D: begin
							e_q <= b1_q; d_q <= b2_q; sp_q <= sp_q + 16'd2;
						end
						cise_pkg::OP_POP_H: begin
							l_q <= b1_q; h_q <= b2_q; sp_q <= sp_q + 16'd2;
						end
						cise_pkg::OP_POP_PSW: begin
							f_q <= b1_q[4:0]; a_q <= b2_q; sp_q <= sp_q + 16'd2;
						end
						cise_pkg::OP_PUSH_B, cise_pkg::OP_PUSH_D, cise_pkg::OP_PUSH_H,
						cise_pkg::OP_PUSH_PSW: sp_q <= sp_q - 16'd2;
						cise_pkg::OP_JNZ:
							pc_q <= ((f_q & cise_pkg::F_Z) != 5'd0) ? pc_q + 16'd3 : imm16;
						cise_pkg::OP_JMP: pc_q <= imm16;
						cise_pkg::OP_CALL: begin pc_q <= imm16; sp_q <= sp_q - 16'd2; end
						cise_pkg::OP_RET: begin pc_q <= imm16; sp_q <= sp_q + 16'd2; end
						cise_pkg::OP_XCHG: begin {h_q, l_q} <= de; {d_q, e_q} <= hl; end
						cise_pkg::OP_EI: ie_q <= 1'b1;
						default: un_q <= 1'b1;
					endcase
					unique case (op_q)
						cise_pkg::OP_LXI_B, cise_pkg::OP_LXI_D, cise_pkg::OP_LXI_H,
						cise_pkg::OP_LXI_SP, cise_pkg::OP_STA, cise_pkg::OP_LDA:
							pc_q <= pc_q + 16'd3;
						cise_pkg::OP_MVI_B, cise_pkg::OP_MVI_C, cise_pkg::OP_MVI_H,
						cise_pkg::OP_MVI_M, cise_pkg::OP_MVI_A, cise_pkg::OP_ADI,
						cise_pkg::OP_OUT, cise_pkg::OP_ANI, cise_pkg::OP_CPI:
							pc_q <= pc_q + 16'd2;
						default: ;
					endcase
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {1'b0, un_q, ie_q, f_q, hl, de, bc, a_q, sp_q, pc_q, rb_q};

	logic unused_ok;
	assign unused_ok = ^s_axis_tdata[31:26];

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("took a request while busy");
	ap_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("ready and result at once");
endmodule

### tb/tb_cpu_instruction_subset_executor_top.sv
// Testbench for cpu_instruction_subset_executor_top: memory writes, reads and
// instruction executions checked against an in-bench predictor of all registers.
// Depends on cise_pkg and the executor RTL.
module tb_cpu_instruction_subset_executor_top;

	localparam bit [7:0] SUPPORTED_OPS [54] = '{cise_pkg::OP_NOP, cise_pkg::OP_NOP_ALT,
		cise_pkg::OP_LXI_B, cise_pkg::OP_DCR_B, cise_pkg::OP_MVI_B, cise_pkg::OP_DAD_B,
		cise_pkg::OP_DCR_C, cise_pkg::OP_MVI_C, cise_pkg::OP_RRC, cise_pkg::OP_LXI_D,
		cise_pkg::OP_INX_D, cise_pkg::OP_DAD_D, cise_pkg::OP_LDAX_D, cise_pkg::OP_DCX_D,
		cise_pkg::OP_LXI_H, cise_pkg::OP_INX_H, cise_pkg::OP_INR_H, cise_pkg::OP_MVI_H,
		cise_pkg::OP_DAD_H, cise_pkg::OP_LXI_SP, cise_pkg::OP_STA, cise_pkg::OP_MVI_M,
		cise_pkg::OP_LDA, cise_pkg::OP_MVI_A, cise_pkg::OP_MOV_DM, cise_pkg::OP_MOV_EM,
		cise_pkg::OP_MOV_HM, cise_pkg::OP_MOV_LA, cise_pkg::OP_MOV_MA, cise_pkg::OP_MOV_AD,
		cise_pkg::OP_MOV_AE, cise_pkg::OP_MOV_AH, cise_pkg::OP_MOV_AM, cise_pkg::OP_ANA_A,
		cise_pkg::OP_XRA_A, cise_pkg::OP_ORA_M, cise_pkg::OP_POP_B, cise_pkg::OP_JNZ,
		cise_pkg::OP_JMP, cise_pkg::OP_PUSH_B, cise_pkg::OP_ADI, cise_pkg::OP_RET,
		cise_pkg::OP_CALL, cise_pkg::OP_POP_D, cise_pkg::OP_OUT, cise_pkg::OP_PUSH_D,
		cise_pkg::OP_POP_H, cise_pkg::OP_PUSH_H, cise_pkg::OP_ANI, cise_pkg::OP_XCHG,
		cise_pkg::OP_POP_PSW, cise_pkg::OP_PUSH_PSW, cise_pkg::OP_EI, cise_pkg::OP_CPI};

	// Same bit order as m_axis_tdata[102:0].
	typedef struct packed {
		bit        unimpl;
		bit        int_en;
		bit [4:0]  flg;
		bit [15:0] hl, de, bc;
		bit [7:0]  acc;
		bit [15:0] sp, pc;
		bit [7:0]  rbyte;
	} cpu_state_t;

	class executor_scoreboard;
		bit [7:0] mem [int];
		bit [7:0] a, b, c, d, e, h, l;
		bit [15:0] sp, pc;
		bit [4:0] flg;
		bit int_en;
		cpu_state_t pending_states [$];
		int errors;
		int checked;

		function bit [7:0] rd(bit [15:0] addr);
			return mem.exists(addr) ? mem[addr] : 8'h00;
		endfunction

		function void wr(bit [15:0] addr, bit [7:0] v);
			mem[addr] = v;
		endfunction

		function void set_zsp(bit [7:0] v);
			flg = flg & ~(cise_pkg::F_Z | cise_pkg::F_S | cise_pkg::F_P);
			if (v == 8'h00) flg |= cise_pkg::F_Z;
			if (v[7]) flg |= cise_pkg::F_S;
			if (!(^v)) flg |= cise_pkg::F_P;
		endfunction

		function void set_carry(bit cy);
			flg = (flg & ~cise_pkg::F_CY) | (cy ? cise_pkg::F_CY : 5'h00);
		endfunction

		function void logic_op(bit [7:0] v);
			a = v;
			set_zsp(v);
			set_carry(1'b0);
		endfunction

		function void add_to_hl(bit [15:0] operand);
			bit [16:0] s;
			s = {1'b0, h, l} + {1'b0, operand};
			{h, l} = s[15:0];
			set_carry(s[16]);
		endfunction

		function void push16(bit [7:0] hi, bit [7:0] lo);
			wr(sp - 16'd1, hi);
			wr(sp - 16'd2, lo);
			sp = sp - 16'd2;
		endfunction

		function bit [15:0] pop16();
			bit [15:0] v;
			v = {rd(sp + 16'd1), rd(sp)};
			sp = sp + 16'd2;
			return v;
		endfunction

		// Runs the instruction at pc; returns 1 for an unsupported opcode.
		function bit run_instruction();
			bit [7:0] op, b1, b2, v;
			bit [15:0] imm, n3, t;
			bit [8:0] s9;
			op = rd(pc);
			b1 = rd(pc + 16'd1);
			b2 = rd(pc + 16'd2);
			imm = {b2, b1};
			n3 = pc + 16'd3;
			pc = pc + 16'd1;
			case (op)
				cise_pkg::OP_NOP, cise_pkg::OP_NOP_ALT: ;
				cise_pkg::OP_LXI_B: begin {b, c} = imm; pc = n3; end
				cise_pkg::OP_DCR_B: begin b = b - 8'd1; set_zsp(b); end
				cise_pkg::OP_MVI_B: begin b = b1; pc = pc + 16'd1; end
				cise_pkg::OP_DAD_B: add_to_hl({b, c});
				cise_pkg::OP_DCR_C: begin c = c - 8'd1; set_zsp(c); end
				cise_pkg::OP_MVI_C: begin c = b1; pc = pc + 16'd1; end
				cise_pkg::OP_RRC: begin set_carry(a[0]); a = {a[0], a[7:1]}; end
				cise_pkg::OP_LXI_D: begin {d, e} = imm; pc = n3; end
				cise_pkg::OP_INX_D: {d, e} = {d, e} + 16'd1;
				cise_pkg::OP_DAD_D: add_to_hl({d, e});
				cise_pkg::OP_LDAX_D: a = rd({d, e});
				cise_pkg::OP_DCX_D: {d, e} = {d, e} - 16'd1;
				cise_pkg::OP_LXI_H: begin {h, l} = imm; pc = n3; end
				cise_pkg::OP_INX_H: {h, l} = {h, l} + 16'd1;
				cise_pkg::OP_INR_H: begin h = h + 8'd1; set_zsp(h); end
				cise_pkg::OP_MVI_H: begin h = b1; pc = pc + 16'd1; end
				cise_pkg::OP_DAD_H: add_to_hl({h, l});
				cise_pkg::OP_LXI_SP: begin sp = imm; pc = n3; end
				cise_pkg::OP_STA: begin wr(imm, a); pc = n3; end
				cise_pkg::OP_MVI_M: begin wr({h, l}, b1); pc = pc + 16'd1; end
				cise_pkg::OP_LDA: begin a = rd(imm); pc = n3; end
				cise_pkg::OP_MVI_A: begin a = b1; pc = pc + 16'd1; end
				cise_pkg::OP_MOV_DM: d = rd({h, l});
				cise_pkg::OP_MOV_EM: e = rd({h, l});
				cise_pkg::OP_MOV_HM: h = rd({h, l});
				cise_pkg::OP_MOV_LA: l = a;
				cise_pkg::OP_MOV_MA: wr({h, l}, a);
				cise_pkg::OP_MOV_AD: a = d;
				cise_pkg::OP_MOV_AE: a = e;
				cise_pkg::OP_MOV_AH: a = h;
				cise_pkg::OP_MOV_AM: a = rd({h, l});
				cise_pkg::OP_ANA_A: logic_op(a);
				cise_pkg::OP_XRA_A: logic_op(8'h00);
				cise_pkg::OP_ORA_M: logic_op(a | rd({h, l}));
				cise_pkg::OP_POP_B: {b, c} = pop16();
				cise_pkg::OP_JNZ: pc = (flg & cise_pkg::F_Z) != 5'h00 ? n3 : imm;
				cise_pkg::OP_JMP: pc = imm;
				cise_pkg::OP_PUSH_B: push16(b, c);
				cise_pkg::OP_ADI: begin
					s9 = {1'b0, a} + {1'b0, b1};
					a = s9[7:0];
					set_zsp(a);
					set_carry(s9[8]);
					pc = pc + 16'd1;
				end
				cise_pkg::OP_RET: pc = pop16();
				cise_pkg::OP_CALL: begin push16(n3[15:8], n3[7:0]); pc = imm; end
				cise_pkg::OP_POP_D: {d, e} = pop16();
				cise_pkg::OP_OUT: pc = pc + 16'd1;
				cise_pkg::OP_PUSH_D: push16(d, e);
				cise_pkg::OP_POP_H: {h, l} = pop16();
				cise_pkg::OP_PUSH_H: push16(h, l);
				cise_pkg::OP_ANI: begin logic_op(a & b1); pc = pc + 16'd1; end
				cise_pkg::OP_XCHG: begin t = {h, l}; {h, l} = {d, e}; {d, e} = t; end
				cise_pkg::OP_POP_PSW: begin t = pop16(); a = t[15:8]; flg = t[4:0]; end
				cise_pkg::OP_PUSH_PSW: push16(a, {3'b000, flg});
				cise_pkg::OP_EI: int_en = 1'b1;
				cise_pkg::OP_CPI: begin
					v = a - b1;
					set_zsp(v);
					set_carry(a < b1);
					pc = pc + 16'd1;
				end
				default: return 1'b1;
			endcase
			return 1'b0;
		endfunction

		// Called for each accepted request; queues the state it should produce.
		function void note_request(bit [1:0] cmd, bit [15:0] addr, bit [7:0] wbyte);
			cpu_state_t st;
			st = '0;
			case (cmd)
				cise_pkg::CMD_WRITE: wr(addr, wbyte);
				cise_pkg::CMD_READ: st.rbyte = rd(addr);
				cise_pkg::CMD_EXEC: st.unimpl = run_instruction();
				default: ;
			endcase
			st.pc = pc;
			st.sp = sp;
			st.acc = a;
			st.bc = {b, c};
			st.de = {d, e};
			st.hl = {h, l};
			st.flg = flg;
			st.int_en = int_en;
			pending_states.push_back(st);
		endfunction

		task report(string what, int got, int want);
			$display("ERROR at %0t: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
			errors++;
		endtask

		task check_result(logic [103:0] data);
			cpu_state_t got, want;
			if (pending_states.size() == 0) begin
				report("unexpected result, tdata low word", int'(data[31:0]), 0);
				return;
			end
			got = cpu_state_t'(data[102:0]);
			want = pending_states.pop_front();
			checked++;
			if (got.rbyte !== want.rbyte) report("read_byte", got.rbyte, want.rbyte);
			if (got.pc !== want.pc) report("program_counter", got.pc, want.pc);
			if (got.sp !== want.sp) report("stack_pointer", got.sp, want.sp);
			if (got.acc !== want.acc) report("accumulator", got.acc, want.acc);
			if (got.bc !== want.bc) report("pair_bc", got.bc, want.bc);
			if (got.de !== want.de) report("pair_de", got.de, want.de);
			if (got.hl !== want.hl) report("pair_hl", got.hl, want.hl);
			if (got.flg !== want.flg) report("flag_bits", got.flg, want.flg);
			if (got.int_en !== want.int_en) report("interrupts_enabled", got.int_en, want.int_en);
			if (got.unimpl !== want.unimpl) report("unimplemented", got.unimpl, want.unimpl);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;

	executor_scoreboard sb = new();
	bit steady = 1'b0;
	int requests_sent = 0;
	int exec_count = 0;
	int unimpl_count = 0;
	bit [15:0] written_addrs [$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	cpu_instruction_subset_executor_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
			m_axis_tready <= steady || ($urandom_range(99) >= 11);
		end
	end

	task send_request(bit [1:0] cmd, bit [15:0] addr, bit [7:0] wbyte);
		if (!steady && $urandom_range(99) < 11) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, wbyte, addr, cmd};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(cmd, addr, wbyte);
		if (cmd == cise_pkg::CMD_WRITE) written_addrs.push_back(addr);
		requests_sent++;
	endtask

	task fill_if_unwritten(bit [15:0] addr);
		if (!sb.mem.exists(addr)) send_request(cise_pkg::CMD_WRITE, addr, 8'($urandom));
	endtask

	// Places an instruction at the program counter when unwritten or at random, makes sure
	// every byte it will read holds data, then executes it.
	task run_one_instruction();
		bit [15:0] pc, hl, de, sp, imm;
		bit [7:0] op;
		pc = sb.pc;
		if (!sb.mem.exists(pc) || !sb.mem.exists(pc + 16'd1) ||
				!sb.mem.exists(pc + 16'd2) || $urandom_range(99) < 70) begin
			if ($urandom_range(99) < 88)
				op = SUPPORTED_OPS[$urandom_range(53)];
			else
				op = 8'($urandom);
			send_request(cise_pkg::CMD_WRITE, pc, op);
			send_request(cise_pkg::CMD_WRITE, pc + 16'd1, 8'($urandom));
			// Keep jump and load targets close now and then so code gets reused.
			send_request(cise_pkg::CMD_WRITE, pc + 16'd2,
				$urandom_range(99) < 50 ? 8'($urandom_range(3)) : 8'($urandom));
		end
		op = sb.rd(pc);
		hl = {sb.h, sb.l};
		de = {sb.d, sb.e};
		sp = sb.sp;
		imm = {sb.rd(pc + 16'd2), sb.rd(pc + 16'd1)};
		case (op)
			cise_pkg::OP_LDAX_D: fill_if_unwritten(de);
			cise_pkg::OP_LDA: fill_if_unwritten(imm);
			cise_pkg::OP_MOV_DM, cise_pkg::OP_MOV_EM, cise_pkg::OP_MOV_HM,
			cise_pkg::OP_MOV_AM, cise_pkg::OP_ORA_M: fill_if_unwritten(hl);
			cise_pkg::OP_POP_B, cise_pkg::OP_POP_D, cise_pkg::OP_POP_H,
			cise_pkg::OP_POP_PSW, cise_pkg::OP_RET: begin
				fill_if_unwritten(sp);
				fill_if_unwritten(sp + 16'd1);
			end
			default: ;
		endcase
		send_request(cise_pkg::CMD_EXEC, 16'($urandom), 8'($urandom));
		exec_count++;
		if (sb.pending_states[$].unimpl) unimpl_count++;
	endtask

	initial begin
		int limit;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, the spare command and a short program.
		send_request(cise_pkg::CMD_SPARE, 16'hffff, 8'hff);
		send_request(cise_pkg::CMD_WRITE, 16'h0000, cise_pkg::OP_LXI_SP);
		send_request(cise_pkg::CMD_WRITE, 16'hffff, 8'hff);
		send_request(cise_pkg::CMD_READ, 16'hffff, 8'h00);
		send_request(cise_pkg::CMD_READ, 16'h0000, 8'hff);
		send_request(cise_pkg::CMD_WRITE, 16'h0001, 8'h00);
		send_request(cise_pkg::CMD_WRITE, 16'h0002, 8'h00);
		send_request(cise_pkg::CMD_EXEC, 16'h0000, 8'h00);  // SP = 0, pushes wrap below zero
		send_request(cise_pkg::CMD_WRITE, 16'h0003, cise_pkg::OP_CALL);
		send_request(cise_pkg::CMD_WRITE, 16'h0004, 8'h10);
		send_request(cise_pkg::CMD_WRITE, 16'h0005, 8'h00);
		send_request(cise_pkg::CMD_EXEC, 16'h0000, 8'h00);
		send_request(cise_pkg::CMD_WRITE, 16'h0010, cise_pkg::OP_PUSH_PSW);
		send_request(cise_pkg::CMD_WRITE, 16'h0011, cise_pkg::OP_POP_PSW);
		send_request(cise_pkg::CMD_WRITE, 16'h0012, 8'hff);  // unsupported opcode
		send_request(cise_pkg::CMD_WRITE, 16'h0013, 8'h00);
		send_request(cise_pkg::CMD_WRITE, 16'h0014, 8'h00);
		send_request(cise_pkg::CMD_EXEC, 16'h0000, 8'h00);
		send_request(cise_pkg::CMD_WRITE, 16'hfffc, 8'hff);  // popped flags set all five flag bits
		send_request(cise_pkg::CMD_EXEC, 16'h0000, 8'h00);
		send_request(cise_pkg::CMD_EXEC, 16'h0000, 8'h00);
		send_request(cise_pkg::CMD_READ, 16'hfffd, 8'h00);

		limit = requests_sent + 900;
		while (requests_sent < limit) begin
			steady = (requests_sent > 300 && requests_sent < 420);
			if (requests_sent > 500 && requests_sent < 510) begin
				// Let the block drain completely before going on.
				s_axis_tvalid <= 1'b0;
				while (sb.pending_states.size() != 0) @(posedge clk);
			end
			case ($urandom_range(19))
				0, 1, 2: send_request(cise_pkg::CMD_WRITE, 16'($urandom), 8'($urandom));
				3, 4: if (written_addrs.size() != 0)
					send_request(cise_pkg::CMD_READ,
						written_addrs[$urandom_range(written_addrs.size() - 1)],
						8'($urandom));
				5: send_request(cise_pkg::CMD_SPARE, 16'($urandom), 8'($urandom));
				default: run_one_instruction();
			endcase
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;
		while (sb.pending_states.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d requests, %0d results checked; %0d instructions executed,",
			requests_sent, sb.checked, exec_count);
		$display("%0d of them unsupported opcodes.", unimpl_count);
		if (sb.errors == 0 && sb.pending_states.size() == 0)
			$display("cpu_instruction_subset_executor_top: match");
		else
			$display("cpu_instruction_subset_executor_top: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout waiting for the executor");
		$display("cpu_instruction_subset_executor_top: mismatch");
		$finish;
	end

endmodule
